// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the heater controller RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/tpwm_pkg.sv -----
// Types and constants for the thermostat PWM heater controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package tpwm_pkg;

    localparam int TEMP_W = 12;
    localparam int CNT_W  = 16;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [1:0] FUNC_TICK    = 2'd0;
    localparam logic [1:0] FUNC_SAMPLE  = 2'd1;
    localparam logic [1:0] FUNC_COMMAND = 2'd2;

    typedef enum logic [2:0] {
        REG_LOW_SETPOINT  = 3'd0,
        REG_HIGH_SETPOINT = 3'd1,
        REG_PWM_PERIOD    = 3'd2,
        REG_ON_TICKS      = 3'd3,
        REG_RUN_TIMEOUT   = 3'd4
    } cfg_reg_t;

    localparam logic signed [TEMP_W-1:0] LOW_SETPOINT_RST  = 12'sd5;
    localparam logic signed [TEMP_W-1:0] HIGH_SETPOINT_RST = 12'sd20;
    localparam logic [CNT_W-1:0] PWM_PERIOD_RST  = 16'd2000;
    localparam logic [CNT_W-1:0] ON_TICKS_RST    = 16'd200;
    localparam logic [CNT_W-1:0] RUN_TIMEOUT_RST = 16'd10000;

    typedef struct packed {
        logic signed [TEMP_W-1:0] low_setpoint;
        logic signed [TEMP_W-1:0] high_setpoint;
        logic [CNT_W-1:0]         run_timeout;
        logic [CNT_W-1:0]         on_len;
        logic [CNT_W-1:0]         off_len;
        logic                     full_on;
        logic                     zero_on;
    } cfg_t;

    typedef struct packed {
        logic                     command_on;
        logic signed [TEMP_W-1:0] temperature;
        logic [1:0]               func;
    } item_t;

    typedef struct packed {
        logic running;
        logic pin_drive;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/tpwm_cfg.sv -----
// Configuration registers and derived PWM phase lengths.
// Depends on tpwm_pkg.
`default_nettype none

module tpwm_cfg (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [15:0]          cfg_wdata,
    output tpwm_pkg::cfg_t            cfg
);
    import tpwm_pkg::*;

    logic signed [TEMP_W-1:0] low_reg;
    logic signed [TEMP_W-1:0] high_reg;
    logic [CNT_W-1:0]         period_reg;
    logic [CNT_W-1:0]         on_reg;
    logic [CNT_W-1:0]         timeout_reg;
    logic [CNT_W-1:0]         on_len;
    logic [CNT_W-1:0]         off_len;
    logic                     full_on;
    logic                     zero_on;
    logic [CNT_W-1:0]         period_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg     <= LOW_SETPOINT_RST;
            high_reg    <= HIGH_SETPOINT_RST;
            period_reg  <= PWM_PERIOD_RST;
            on_reg      <= ON_TICKS_RST;
            timeout_reg <= RUN_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LOW_SETPOINT:  low_reg     <= $signed(cfg_wdata[TEMP_W-1:0]);
                REG_HIGH_SETPOINT: high_reg    <= $signed(cfg_wdata[TEMP_W-1:0]);
                REG_PWM_PERIOD:    period_reg  <= cfg_wdata;
                REG_ON_TICKS:      on_reg      <= cfg_wdata;
                REG_RUN_TIMEOUT:   timeout_reg <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // zero period acts as one tick; on time saturates to the period
    always_comb
    begin
        period_eff = (period_reg == '0) ? CNT_W'(1) : period_reg;
        on_len     = (on_reg > period_eff) ? period_eff : on_reg;
        off_len    = period_eff - on_len;
        full_on    = (on_len == period_eff);
        zero_on    = (on_len == '0);
    end

    assign cfg.low_setpoint  = low_reg;
    assign cfg.high_setpoint = high_reg;
    assign cfg.run_timeout   = timeout_reg;
    assign cfg.on_len        = on_len;
    assign cfg.off_len       = off_len;
    assign cfg.full_on       = full_on;
    assign cfg.zero_on       = zero_on;

endmodule

`default_nettype wire

// ----- rtl/tpwm_ctrl.sv -----
// Run state, PWM phase and timeout counters; next state and result per beat.
// Depends on tpwm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tpwm_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire tpwm_pkg::item_t      item,
    input  wire tpwm_pkg::cfg_t       cfg,
    output tpwm_pkg::result_t         result
);
    import tpwm_pkg::*;

    logic             run_reg;
    logic             run_next;
    logic             phase_on_reg;
    logic             phase_on_next;
    logic [CNT_W-1:0] phase_cnt_reg;
    logic [CNT_W-1:0] phase_cnt_next;
    logic [CNT_W-1:0] timeout_cnt_reg;
    logic [CNT_W-1:0] timeout_cnt_next;
    logic [CNT_W-1:0] tick_timeout;
    logic [CNT_W-1:0] tick_phase;
    logic [CNT_W-1:0] phase_len;
    logic             do_start;
    logic             do_stop;

    always_comb
    begin
        run_next         = run_reg;
        phase_on_next    = phase_on_reg;
        phase_cnt_next   = phase_cnt_reg;
        timeout_cnt_next = timeout_cnt_reg;
        do_start         = 1'b0;
        do_stop          = 1'b0;

        tick_timeout = (timeout_cnt_reg < CNT_MAX) ? timeout_cnt_reg + 1'b1 : timeout_cnt_reg;
        tick_phase   = (phase_cnt_reg < CNT_MAX) ? phase_cnt_reg + 1'b1 : phase_cnt_reg;
        phase_len    = phase_on_reg ? cfg.on_len : cfg.off_len;

        case (item.func)
            FUNC_TICK:
            begin
                if (run_reg)
                begin
                    if (tick_timeout >= cfg.run_timeout)
                    begin
                        do_stop = 1'b1;
                    end
                    else if (tick_phase >= phase_len)
                    begin
                        timeout_cnt_next = tick_timeout;
                        phase_on_next    = !phase_on_reg;
                        phase_cnt_next   = '0;
                    end
                    else
                    begin
                        timeout_cnt_next = tick_timeout;
                        phase_cnt_next   = tick_phase;
                    end
                end
            end
            FUNC_SAMPLE:
            begin
                if (item.temperature < $signed(cfg.low_setpoint))
                    do_start = !run_reg;
                else if (item.temperature > $signed(cfg.high_setpoint))
                    do_stop = 1'b1;
            end
            FUNC_COMMAND:
            begin
                if (item.command_on)
                    do_start = !run_reg;
                else
                    do_stop = 1'b1;
            end
            default: ;
        endcase

        if (do_start)
        begin
            run_next         = 1'b1;
            phase_on_next    = 1'b1;
            phase_cnt_next   = '0;
            timeout_cnt_next = '0;
        end
        if (do_stop)
        begin
            run_next         = 1'b0;
            phase_on_next    = 1'b0;
            phase_cnt_next   = '0;
            timeout_cnt_next = '0;
        end

        result.running   = run_next;
        result.pin_drive = run_next && !cfg.zero_on && (cfg.full_on || phase_on_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg         <= 1'b0;
            phase_on_reg    <= 1'b0;
            phase_cnt_reg   <= '0;
            timeout_cnt_reg <= '0;
        end
        else if (step)
        begin
            run_reg         <= run_next;
            phase_on_reg    <= phase_on_next;
            phase_cnt_reg   <= phase_cnt_next;
            timeout_cnt_reg <= timeout_cnt_next;
        end
    end

    `ASSERT_SAME(idle_counters_clear, !run_reg,
        !phase_on_reg && (phase_cnt_reg == '0) && (timeout_cnt_reg == '0))
    `ASSERT_NEXT(stop_command_stops, step && (item.func == FUNC_COMMAND) && !item.command_on,
        !run_reg)
    `ASSERT_NEXT(state_holds_without_step, !step,
        $stable(run_reg) && $stable(phase_on_reg) && $stable(timeout_cnt_reg))

endmodule

`default_nettype wire

// ----- rtl/thermostat_pwm_heater_control_top.sv -----
// Top level of the thermostat PWM heater controller: input and result registers.
// Depends on tpwm_pkg, tpwm_cfg, tpwm_ctrl and assert_macros.svh.
//
//   channel   dir   beat layout (lsb first)                       handshake
//   cfg       in    cfg_index, cfg_wdata                          cfg_we
//   s         in    func[1:0] temperature[13:2] command_on[14]    s_tvalid/s_tready
//   m         out   pin_drive[0] running[1]                       m_tvalid/m_tready
//
// One beat per clock while results drain; input register, then result register.
// Rate is set by the single update of the run/phase/timeout counters per beat.
// Reset (rst_n low, asynchronous) clears run state and loads register defaults.
// A held result stalls the input register; s_tready stays high while it can drain.
`default_nettype none
`include "assert_macros.svh"

module thermostat_pwm_heater_control_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // func[1:0], temperature[13:2], command_on[14], zero[15]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // pin_drive[0], running[1], zero[7:2]
);
    import tpwm_pkg::*;

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    logic    in_valid_next;
    result_t result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    step;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_item_reg <= item_t'(s_tdata[14:0]);
    end

    tpwm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tpwm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.running, out_reg.pin_drive};

    `ASSERT_SAME(idle_pin_off, out_valid_reg && !out_reg.running, !out_reg.pin_drive)
    `ASSERT_NEXT(stalled_item_kept, in_valid_reg && !advance, in_valid_reg)

endmodule

`default_nettype wire

// ----- tb/tb_thermostat_pwm_heater_control_top.sv -----
// Self-checking testbench for thermostat_pwm_heater_control_top: table-driven and random
// beats over several register settings; checked by built-in predictor or typed table rows.
// Depends on tpwm_pkg and the heater controller RTL only.
`timescale 1ns / 100ps

module tb_thermostat_pwm_heater_control_top;

    import tpwm_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES = 12;
    localparam int FIXED_PHASES = 5;
    localparam int BEATS_PER_PHASE = 106;
    localparam int LONG_HOLD_AT = 400;
    localparam int LONG_HOLD_CYCLES = 90;

    typedef struct {
        logic signed [TEMP_W-1:0] low;
        logic signed [TEMP_W-1:0] high;
        logic [CNT_W-1:0]         period;
        logic [CNT_W-1:0]         on_len;
        logic [CNT_W-1:0]         timeout;
    } heater_setting_t;

    typedef struct {
        item_t   item;
        bit      typed;
        result_t want;
    } heater_row_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // func[1:0], temperature[13:2], command_on[14], zero[15]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // pin_drive[0], running[1], zero[7:2]

    // predictor state and settings
    heater_setting_t heater_cfg;
    bit              run_active = 1'b0;
    bit              phase_on = 1'b0;
    logic [CNT_W-1:0] phase_cnt = '0;
    logic [CNT_W-1:0] timeout_cnt = '0;

    result_t     heater_expect_q[$];
    heater_row_t directed_rows[$];

    int  mismatches = 0;
    int  beats_sent = 0;
    int  results_seen = 0;
    int  settings_used = 0;
    int  runs_started = 0;
    int  runs_timed_out = 0;
    int  phase_flips = 0;
    int  idle_cycles = 0;
    bit  no_idle = 1'b0;
    bit  long_hold_done = 1'b0;

    thermostat_pwm_heater_control_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < 30)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic void heater_start();
        if (!run_active)
        begin
            run_active = 1'b1;
            phase_on = 1'b1;
            phase_cnt = '0;
            timeout_cnt = '0;
            runs_started++;
        end
    endfunction

    function automatic void heater_stop();
        run_active = 1'b0;
        phase_on = 1'b0;
        phase_cnt = '0;
        timeout_cnt = '0;
    endfunction

    function automatic result_t heater_predict(input item_t it);
        result_t          r;
        logic [CNT_W-1:0] per_len;
        logic [CNT_W-1:0] on_len;
        logic [CNT_W-1:0] ph_len;
        per_len = (heater_cfg.period == '0) ? 16'd1 : heater_cfg.period;
        on_len = (heater_cfg.on_len > per_len) ? per_len : heater_cfg.on_len;
        case (it.func)
            FUNC_TICK:
            begin
                if (run_active)
                begin
                    if (timeout_cnt != CNT_MAX)
                        timeout_cnt++;
                    if (timeout_cnt >= heater_cfg.timeout)
                    begin
                        heater_stop();
                        runs_timed_out++;
                    end
                    else
                    begin
                        if (phase_cnt != CNT_MAX)
                            phase_cnt++;
                        ph_len = phase_on ? on_len : per_len - on_len;
                        if (phase_cnt >= ph_len)
                        begin
                            phase_on = !phase_on;
                            phase_cnt = '0;
                            phase_flips++;
                        end
                    end
                end
            end
            FUNC_SAMPLE:
            begin
                if (it.temperature < heater_cfg.low)
                    heater_start();
                else if (it.temperature > heater_cfg.high)
                    heater_stop();
            end
            FUNC_COMMAND:
            begin
                if (it.command_on)
                    heater_start();
                else
                    heater_stop();
            end
            default:
            begin
            end
        endcase
        r.running = run_active;
        r.pin_drive = run_active && (on_len != '0) && ((on_len == per_len) || phase_on);
        return r;
    endfunction

    function automatic void add_row(input logic [1:0] f, input int t, input bit c,
                                    input bit typed, input bit pin, input bit run);
        heater_row_t row;
        row.item.func = f;
        row.item.temperature = TEMP_W'(t);
        row.item.command_on = c;
        row.typed = typed;
        row.want.pin_drive = pin;
        row.want.running = run;
        directed_rows.push_back(row);
    endfunction

    function automatic heater_setting_t mk_setting(input int low, input int high, input int period,
                                                   input int on_len, input int timeout);
        heater_setting_t s;
        s.low = TEMP_W'(low);
        s.high = TEMP_W'(high);
        s.period = CNT_W'(period);
        s.on_len = CNT_W'(on_len);
        s.timeout = CNT_W'(timeout);
        return s;
    endfunction

    function automatic heater_setting_t rand_setting();
        heater_setting_t s;
        if ($urandom_range(0, 3) == 0)
        begin
            s.low = TEMP_W'($urandom);
            s.high = TEMP_W'($urandom);
        end
        else
        begin
            s.low = TEMP_W'($urandom_range(0, 400) - 200);
            s.high = TEMP_W'(s.low + $urandom_range(0, 60));
        end
        case ($urandom_range(0, 4))
            0: s.period = CNT_W'($urandom_range(0, 1));
            1: s.period = CNT_W'($urandom_range(2, 6));
            2: s.period = CNT_W'($urandom_range(7, 40));
            3: s.period = CNT_MAX;
            default: s.period = CNT_W'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0: s.on_len = '0;
            1: s.on_len = s.period;
            2: s.on_len = CNT_W'(s.period + 1'b1);
            3: s.on_len = CNT_W'($urandom_range(0, s.period));
            default: s.on_len = CNT_W'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0: s.timeout = CNT_W'($urandom_range(0, 2));
            1: s.timeout = CNT_W'($urandom_range(3, 30));
            2: s.timeout = CNT_W'($urandom_range(31, 120));
            3: s.timeout = CNT_MAX;
            default: s.timeout = CNT_W'($urandom);
        endcase
        return s;
    endfunction

    function automatic item_t rand_item();
        item_t it;
        int    pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            it.func = FUNC_TICK;
        else if (pick < 85)
            it.func = FUNC_SAMPLE;
        else if (pick < 96)
            it.func = FUNC_COMMAND;
        else
            it.func = FUNC_UNUSED;
        case ($urandom_range(0, 3))
            0: it.temperature = TEMP_W'(heater_cfg.low + $urandom_range(0, 6) - 3);
            1: it.temperature = TEMP_W'(heater_cfg.high + $urandom_range(0, 6) - 3);
            default: it.temperature = TEMP_W'($urandom);
        endcase
        it.command_on = ($urandom_range(0, 3) != 0);
        return it;
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic write_settings(input heater_setting_t s);
        write_reg(REG_LOW_SETPOINT, {{4{s.low[TEMP_W-1]}}, s.low});
        write_reg(REG_HIGH_SETPOINT, {{4{s.high[TEMP_W-1]}}, s.high});
        write_reg(REG_PWM_PERIOD, s.period);
        write_reg(REG_ON_TICKS, s.on_len);
        write_reg(REG_RUN_TIMEOUT, s.timeout);
        cfg_we <= 1'b0;
        heater_cfg = s;
        settings_used++;
    endtask

    task automatic offer_item(input item_t it, input bit typed, input result_t want);
        result_t r;
        if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, it};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = heater_predict(it);
        heater_expect_q.push_back(typed ? want : r);
        beats_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (heater_expect_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[1:0];
            results_seen++;
            if (heater_expect_q.size() == 0)
                report_mismatch($sformatf("result beat %0d with nothing expected", results_seen));
            else
            begin
                want = heater_expect_q.pop_front();
                if (got.pin_drive !== want.pin_drive)
                    report_mismatch($sformatf("result %0d pin_drive got %b want %b",
                                              results_seen, got.pin_drive, want.pin_drive));
                if (got.running !== want.running)
                    report_mismatch($sformatf("result %0d running got %b want %b",
                                              results_seen, got.running, want.running));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", idle_cycles);
                $display("tb_thermostat_pwm_heater_control_top: FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : result_sink
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && results_seen >= LONG_HOLD_AT)
            begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        heater_setting_t fixed_settings[FIXED_PHASES];
        heater_setting_t st;
        result_t         none;
        heater_setting_t reset_setting;

        none = '0;
        reset_setting.low = LOW_SETPOINT_RST;
        reset_setting.high = HIGH_SETPOINT_RST;
        reset_setting.period = PWM_PERIOD_RST;
        reset_setting.on_len = ON_TICKS_RST;
        reset_setting.timeout = RUN_TIMEOUT_RST;
        heater_cfg = reset_setting;

        fixed_settings[0] = mk_setting(-10, 10, 3, 1, 9);
        fixed_settings[1] = mk_setting(-2048, 2047, 0, 0, 0);
        fixed_settings[2] = mk_setting(2047, -2048, 4, 65535, 65535);
        fixed_settings[3] = mk_setting(0, 0, 65535, 65535, 1);
        fixed_settings[4] = mk_setting(-3, 3, 1, 0, 40);

        //       func          temp   cmd typed pin run
        add_row(FUNC_TICK,       0,    0, 1,    0,  0);
        add_row(FUNC_UNUSED,    -1,    1, 1,    0,  0);
        add_row(FUNC_SAMPLE,  2047,    0, 1,    0,  0);
        add_row(FUNC_SAMPLE,     5,    0, 1,    0,  0);
        add_row(FUNC_SAMPLE,     4,    0, 1,    1,  1);
        add_row(FUNC_SAMPLE, -2048,    0, 1,    1,  1);
        add_row(FUNC_TICK,       0,    0, 0,    0,  0);
        add_row(FUNC_COMMAND,    0,    1, 0,    0,  0);
        add_row(FUNC_SAMPLE,    20,    0, 1,    1,  1);
        add_row(FUNC_SAMPLE,    21,    0, 1,    0,  0);
        add_row(FUNC_COMMAND,    0,    1, 1,    1,  1);
        add_row(FUNC_COMMAND,   -1,    0, 1,    0,  0);
        add_row(FUNC_COMMAND,    0,    0, 1,    0,  0);
        add_row(FUNC_TICK,      -1,    1, 1,    0,  0);
        add_row(FUNC_SAMPLE, -2048,    1, 1,    1,  1);
        add_row(FUNC_UNUSED,     0,    0, 1,    1,  1);
        add_row(FUNC_SAMPLE,  2047,    1, 1,    0,  0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        drain_results();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            st = (ph < FIXED_PHASES) ? fixed_settings[ph] : rand_setting();
            if (ph == PHASES - 1)
                no_idle = 1'b1;
            write_settings(st);
            for (int n = 0; n < BEATS_PER_PHASE; n++)
                offer_item(rand_item(), 1'b0, none);
            drain_results();
        end

        repeat (8) @(posedge clk);
        if (heater_expect_q.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      heater_expect_q.size()));

        $display("covered %0d beats over %0d register settings, %0d results checked",
                 beats_sent, settings_used, results_seen);
        $display("heating runs started %0d, ended by timeout %0d, PWM phase flips %0d",
                 runs_started, runs_timed_out, phase_flips);
        if (mismatches == 0)
            $display("tb_thermostat_pwm_heater_control_top: PASS");
        else
            $display("tb_thermostat_pwm_heater_control_top: FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/tpwm_pkg.sv
rtl/tpwm_cfg.sv
rtl/tpwm_ctrl.sv
rtl/thermostat_pwm_heater_control_top.sv
tb/tb_thermostat_pwm_heater_control_top.sv
